FILE: hdl/bpc_pkg.sv
// Shared types and constants for the button press classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bpc_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int CFG_WIDTH      = 16;
	localparam int IDX_WIDTH      = 2;
	localparam int TAP_WIDTH      = 8;
	localparam int DATA_IN_WIDTH  = 8;
	localparam int DATA_OUT_WIDTH = 8;

	localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_WIDTH-1:0] DOUBLE_TAP_RST = 16'd300;
	localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST = 16'd1000;

	localparam logic [TAP_WIDTH-1:0] TAP_MAX = '1;

	typedef enum logic [IDX_WIDTH-1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_DOUBLE_TAP = 2'd1,
		REG_LONG_PRESS = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_NORMAL = 2'd1,
		KIND_DOUBLE = 2'd2,
		KIND_LONG   = 2'd3
	} press_kind_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] debounce_ticks;
		logic [CFG_WIDTH-1:0] double_tap_ticks;
		logic [CFG_WIDTH-1:0] long_press_ticks;
	} bpc_cfg_t;

	typedef struct packed {
		logic pin_level;
		logic clear_request;
	} bpc_sample_t;

	typedef struct packed {
		logic        press_pending;
		press_kind_t press_kind;
		logic        raw_level;
	} bpc_result_t;

endpackage

FILE: hdl/bpc_cfg.sv
// Configuration register file for the button press classifier.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_cfg
	import bpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [IDX_WIDTH-1:0] wr_index,
	input  logic [CFG_WIDTH-1:0] wr_data,
	output bpc_cfg_t             cfg
);

	bpc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= DEBOUNCE_RST;
			cfg_q.double_tap_ticks <= DOUBLE_TAP_RST;
			cfg_q.long_press_ticks <= LONG_PRESS_RST;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_DEBOUNCE:   cfg_q.debounce_ticks   <= wr_data;
				REG_DOUBLE_TAP: cfg_q.double_tap_ticks <= wr_data;
				REG_LONG_PRESS: cfg_q.long_press_ticks <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/bpc_core.sv
// Per-tick state update: debounce, tap series tracking and press classing.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_core
	import bpc_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  bpc_sample_t sample,
	input  bpc_cfg_t    cfg,
	output bpc_result_t result
);

	logic [TIME_WIDTH-1:0] tick_q, trans_q, down_t_q, up_t_q;
	logic                  down_q, await_q, pend_q;
	logic [TAP_WIDTH-1:0]  tap_q;
	press_kind_t           kind_q;

	logic [TIME_WIDTH-1:0] tick_n, trans_n, down_t_n, up_t_n;
	logic                  down_n, await_n, pend_n;
	logic [TAP_WIDTH-1:0]  tap_n;
	press_kind_t           kind_n;

	logic [TIME_WIDTH-1:0] since_trans, since_up, held;
	logic                  over_db, over_dt, over_long;

	assign tick_n      = tick_q + TIME_WIDTH'(1);
	assign since_trans = tick_n - trans_q;
	assign since_up    = tick_n - up_t_q;
	assign held        = up_t_q - down_t_q;
	assign over_db     = since_trans > TIME_WIDTH'(cfg.debounce_ticks);
	assign over_dt     = since_up > TIME_WIDTH'(cfg.double_tap_ticks);
	assign over_long   = held > TIME_WIDTH'(cfg.long_press_ticks);

	always_comb begin
		trans_n  = trans_q;
		down_t_n = down_t_q;
		up_t_n   = up_t_q;
		down_n   = down_q;
		await_n  = await_q;
		tap_n    = tap_q;
		pend_n   = pend_q;
		kind_n   = kind_q;
		if (sample.clear_request) begin
			pend_n = 1'b0;
			kind_n = KIND_NONE;
		end
		if (!sample.pin_level) begin
			if (!down_q && over_db) begin
				down_t_n = tick_n;
				trans_n  = tick_n;
				down_n   = 1'b1;
				if (over_dt) begin
					tap_n = TAP_WIDTH'(1);
				end else if (tap_q != TAP_MAX) begin
					tap_n = tap_q + TAP_WIDTH'(1);
				end
			end
		end else if (down_q) begin
			if (over_db) begin
				up_t_n  = tick_n;
				trans_n = tick_n;
				down_n  = 1'b0;
				await_n = 1'b1;
			end
		end else if (await_q && over_dt) begin
			await_n = 1'b0;
			pend_n  = 1'b1;
			if (over_long) begin
				kind_n = KIND_LONG;
			end else if (tap_q > TAP_WIDTH'(1)) begin
				kind_n = KIND_DOUBLE;
			end else begin
				kind_n = KIND_NORMAL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			trans_q  <= '0;
			down_t_q <= '0;
			up_t_q   <= '0;
			down_q   <= 1'b0;
			await_q  <= 1'b0;
			tap_q    <= '0;
			pend_q   <= 1'b0;
			kind_q   <= KIND_NONE;
		end else if (en) begin
			tick_q   <= tick_n;
			trans_q  <= trans_n;
			down_t_q <= down_t_n;
			up_t_q   <= up_t_n;
			down_q   <= down_n;
			await_q  <= await_n;
			tap_q    <= tap_n;
			pend_q   <= pend_n;
			kind_q   <= kind_n;
		end
	end

	always_comb begin
		result.press_pending = pend_n;
		result.press_kind    = kind_n;
		result.raw_level     = sample.pin_level;
	end

endmodule

FILE: hdl/button_press_classifier.sv
// Top level of the button press classifier: input register, state update, result register.
// Depends on bpc_pkg, bpc_cfg and bpc_core.
`timescale 1ns / 1ps
//
//  channel  | direction | tdata bits (low to high)
//  s_axis   | in        | pin_level, clear_request, 6 zero bits
//  m_axis   | out       | press_pending, press_kind[1:0], raw_level, 4 zero bits
//  wr_*     | in        | register write, index 0..2, 16-bit data
//
// One request per cycle unless stalled; each result passes input and output registers.
// Reset clears the tick counter, all times, flags and tap count; registers take defaults.
// A stalled result holds in the output register while one more request waits in the
// input register; tready drops only when both are full.

module button_press_classifier
	import bpc_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [DATA_IN_WIDTH-1:0]  s_tdata,   // pin_level, clear_request
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [DATA_OUT_WIDTH-1:0] m_tdata,   // press_pending, press_kind, raw_level
	input  logic                      wr_en,
	input  logic [IDX_WIDTH-1:0]      wr_index,
	input  logic [CFG_WIDTH-1:0]      wr_data
);

	logic        valid_s1, valid_s2, adv_s1;
	bpc_sample_t sample_s1;
	bpc_result_t res_next, res_s2;
	bpc_cfg_t    cfg;

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1.pin_level     <= s_tdata[0];
			sample_s1.clear_request <= s_tdata[1];
		end
		if (adv_s1) res_s2 <= res_next;
	end

	bpc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	bpc_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.sample (sample_s1),
		.cfg    (cfg),
		.result (res_next)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, res_s2.raw_level, res_s2.press_kind, res_s2.press_pending};

endmodule

FILE: bench/testbench.sv
// Self-checking bench for button_press_classifier: random and directed tick streams,
// a cycle-free predictor of the debounce and tap logic, and a result scoreboard.
// Depends on bpc_pkg and the button_press_classifier RTL.
`timescale 1ns / 1ps

module testbench;
	import bpc_pkg::*;

	localparam logic [IDX_WIDTH-1:0] REG_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;

	class press_scoreboard;
		logic [CFG_WIDTH-1:0] debounce_ticks = DEBOUNCE_RST;
		logic [CFG_WIDTH-1:0] double_tap_ticks = DOUBLE_TAP_RST;
		logic [CFG_WIDTH-1:0] long_press_ticks = LONG_PRESS_RST;
		logic [TIME_WIDTH_DEF-1:0] tick_now = '0;
		logic [TIME_WIDTH_DEF-1:0] last_edge = '0;
		logic [TIME_WIDTH_DEF-1:0] last_down = '0;
		logic [TIME_WIDTH_DEF-1:0] last_up = '0;
		bit button_held = 0;
		bit window_open = 0;
		bit pending = 0;
		logic [TAP_WIDTH-1:0] taps = '0;
		press_kind_t kind = KIND_NONE;
		bpc_result_t due[$];
		int errors = 0;

		function void set_reg(logic [IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] value);
			case (idx)
				REG_DEBOUNCE:   debounce_ticks = value;
				REG_DOUBLE_TAP: double_tap_ticks = value;
				REG_LONG_PRESS: long_press_ticks = value;
				default: ;
			endcase
		endfunction

		function bit elapsed_over(logic [TIME_WIDTH_DEF-1:0] since,
				logic [CFG_WIDTH-1:0] limit);
			logic [TIME_WIDTH_DEF-1:0] span;
			span = tick_now - since;
			return span > limit;
		endfunction

		function void note_sample(bit pin, bit clr);
			logic [TIME_WIDTH_DEF-1:0] held;
			bpc_result_t r;
			tick_now = tick_now + 1'b1;
			if (clr) begin
				pending = 0;
				kind = KIND_NONE;
			end
			if (!pin) begin
				if (!button_held && elapsed_over(last_edge, debounce_ticks)) begin
					last_down = tick_now;
					last_edge = tick_now;
					button_held = 1;
					if (elapsed_over(last_up, double_tap_ticks))
						taps = 1;
					else if (taps != TAP_MAX)
						taps = taps + 1'b1;
				end
			end else if (button_held) begin
				if (elapsed_over(last_edge, debounce_ticks)) begin
					last_up = tick_now;
					last_edge = tick_now;
					button_held = 0;
					window_open = 1;
				end
			end else if (window_open && elapsed_over(last_up, double_tap_ticks)) begin
				held = last_up - last_down;
				window_open = 0;
				pending = 1;
				if (held > long_press_ticks)
					kind = KIND_LONG;
				else if (taps > 1)
					kind = KIND_DOUBLE;
				else
					kind = KIND_NORMAL;
			end
			r.press_pending = pending;
			r.press_kind = kind;
			r.raw_level = pin;
			due.push_back(r);
		endfunction

		function void check_result(logic [DATA_OUT_WIDTH-1:0] d);
			bpc_result_t want;
			if (due.size() == 0) begin
				$error("result 0x%02h with no request outstanding", d);
				errors++;
				return;
			end
			want = due.pop_front();
			if (d[0] !== want.press_pending) begin
				$error("press_pending: expected %0d, got %0d", want.press_pending, d[0]);
				errors++;
			end
			if (d[2:1] !== want.press_kind) begin
				$error("press_kind: expected %0d, got %0d", want.press_kind, d[2:1]);
				errors++;
			end
			if (d[3] !== want.raw_level) begin
				$error("raw_level: expected %0d, got %0d", want.raw_level, d[3]);
				errors++;
			end
			if (d[7:4] !== 4'd0) begin
				$error("padding: expected 0, got %0d", d[7:4]);
				errors++;
			end
		endfunction

		function int outstanding();
			return due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DATA_IN_WIDTH-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [DATA_OUT_WIDTH-1:0] m_tdata;
	logic wr_en = 1'b0;
	logic [IDX_WIDTH-1:0] wr_index = '0;
	logic [CFG_WIDTH-1:0] wr_data = '0;

	press_scoreboard sb = new;
	bit quiet = 0;
	int idle_cycles = 0;
	int stall_left = 0;

	always #2 clk = ~clk;

	button_press_classifier i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_sample(bit pin, bit clr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, clr, pin};
		do @(posedge clk); while (!s_tready);
		sb.note_sample(pin, clr);
	endtask

	task automatic play_run(bit pin, int len, bit clr_all);
		for (int i = 0; i < len; i++)
			send_sample(pin, clr_all);
	endtask

	task automatic burst(int n);
		int sent;
		int len;
		int r;
		bit lvl;
		sent = 0;
		lvl = 1;
		while (sent < n) begin
			if ($urandom_range(0, 6) != 0)
				lvl = ~lvl;
			r = $urandom_range(0, 99);
			if (r < 20)
				len = $urandom_range(1, 2);
			else if (r < 40)
				len = int'(sb.debounce_ticks) + int'($urandom_range(0, 3)) - 1;
			else if (r < 65)
				len = int'(sb.double_tap_ticks) + int'($urandom_range(0, 3)) - 1;
			else if (r < 80)
				len = int'(sb.long_press_ticks) + int'($urandom_range(0, 3)) - 1;
			else
				len = $urandom_range(1, int'(sb.debounce_ticks)
					+ int'(sb.double_tap_ticks) + 5);
			if (len < 1)
				len = 1;
			for (int i = 0; i < len; i++)
				send_sample(lvl, $urandom_range(0, 11) == 0);
			sent += len;
		end
	endtask

	// hold until every result is back, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** button_press_classifier: FAILED **");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		burst(400);

		settle();
		write_reg(REG_DEBOUNCE, 16'd1);
		write_reg(REG_DOUBLE_TAP, 16'd2);
		write_reg(REG_LONG_PRESS, 16'd3);
		play_run(0, 2, 0);
		play_run(1, 4, 1);
		play_run(0, 2, 0);
		play_run(1, 1, 0);
		play_run(0, 2, 0);
		play_run(1, 4, 0);
		play_run(0, 5, 0);
		play_run(1, 4, 1);
		play_run(0, 1, 0);
		play_run(1, 1, 0);

		settle();
		write_reg(REG_DEBOUNCE, 16'hFFFF);
		write_reg(REG_DOUBLE_TAP, 16'hFFFF);
		write_reg(REG_LONG_PRESS, 16'hFFFF);
		write_reg(REG_SPARE, 16'($urandom));
		repeat (30) send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

		settle();
		write_reg(REG_DEBOUNCE, 16'd0);
		write_reg(REG_DOUBLE_TAP, 16'd0);
		write_reg(REG_LONG_PRESS, 16'd0);
		burst(200);

		// drive the tap series into saturation
		settle();
		quiet = 1;
		write_reg(REG_DOUBLE_TAP, 16'd4);
		write_reg(REG_LONG_PRESS, 16'hFFFF);
		for (int i = 0; i < 520; i++)
			send_sample(i[0], 0);
		play_run(1, 8, 0);

		for (int ph = 0; ph < 6; ph++) begin
			settle();
			quiet = ph[0];
			write_reg(REG_DEBOUNCE, 16'($urandom_range(0, 6)));
			write_reg(REG_DOUBLE_TAP, 16'($urandom_range(0, 25)));
			write_reg(REG_LONG_PRESS, 16'($urandom_range(0, 40)));
			if ($urandom_range(0, 1))
				write_reg(REG_SPARE, 16'($urandom));
			burst(100);
		end

		settle();
		repeat (6) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("** button_press_classifier: PASSED **");
		else
			$display("** button_press_classifier: FAILED **");
		$finish;
	end

endmodule
